FILE: design/dfwd_pkg.sv
// shared types, codes and the range-overlap helper function of the double-fetch window detector
package dfwd_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [2:0] CMD_OUTSIDE    = 3'd0;
  localparam logic [2:0] CMD_INSIDE     = 3'd1;
  localparam logic [2:0] CMD_ACTIVATE   = 3'd2;
  localparam logic [2:0] CMD_DEACTIVATE = 3'd3;
  localparam logic [2:0] CMD_INIT       = 3'd4;
  localparam logic [2:0] CMD_DESTROY    = 3'd5;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_RECORD,
    OP_CHECK,
    OP_OUT_WRITE,
    OP_IN_COUNT,
    OP_ACTIVATE,
    OP_DEACTIVATE,
    OP_INIT,
    OP_DESTROY
  } op_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [63:0] access_addr;
    logic [31:0] access_size;
    logic        write_access;
    logic        used_in_compare;
    logic        func_known;
    logic [31:0] func_id;
  } in_item_t;

  typedef struct packed {
    logic        double_fetch;
    logic [31:0] outside_count;
    logic [31:0] inside_count;
  } out_item_t;

  // classified operation handed from the front to the back
  typedef struct packed {
    op_t         op;
    logic [63:0] addr;
    logic [31:0] size;
    logic        known;
    logic [31:0] func;
  } op_item_t;

  // byte ranges compared by distance, zero length overlaps nothing
  function automatic logic ranges_overlap(input logic [63:0] a, input logic [31:0] sa,
                                          input logic [63:0] b, input logic [31:0] sb);
    logic res;
    res = 1'b0;
    if (sa != '0 && sb != '0) begin
      if (a <= b) begin
        res = (b - a) < {32'd0, sa};
      end else begin
        res = (a - b) < {32'd0, sb};
      end
    end
    return res;
  endfunction

endpackage

FILE: design/dfwd_fifo.sv
// small synchronous queue used between the stages and at the result side
module dfwd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             push_ok;
  logic             pop_ok;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign rdata   = mem[rd_ptr];
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push_ok && !pop_ok) begin
        count <= count + 1'b1;
      end else if (pop_ok && !push_ok) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

FILE: design/dfwd_front.sv
// front end: decodes each accepted transaction into a back-end operation
module dfwd_front (
  input  dfwd_pkg::in_item_t in_item,
  output dfwd_pkg::op_item_t op_item
);
  import dfwd_pkg::*;

  op_t op;

  always_comb begin
    op = OP_NONE;
    case (in_item.command)
      CMD_OUTSIDE: begin
        // address zero is no access at all
        if (in_item.access_addr != '0) begin
          if (in_item.write_access) begin
            op = OP_OUT_WRITE;
          end else if (in_item.used_in_compare) begin
            op = OP_RECORD;
          end else begin
            op = OP_CHECK;
          end
        end
      end
      CMD_INSIDE:     op = OP_IN_COUNT;
      CMD_ACTIVATE:   op = OP_ACTIVATE;
      CMD_DEACTIVATE: op = OP_DEACTIVATE;
      CMD_INIT:       op = OP_INIT;
      CMD_DESTROY:    op = OP_DESTROY;
      default:        op = OP_NONE;
    endcase
  end

  assign op_item.op    = op;
  assign op_item.addr  = in_item.access_addr;
  assign op_item.size  = in_item.access_size;
  assign op_item.known = in_item.func_known;
  assign op_item.func  = in_item.func_id;

endmodule

FILE: design/dfwd_back.sv
// back end: compare window, lifecycle flags and access counters
module dfwd_back #(
  parameter int WINDOW_DEPTH = 3
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data,
  input  logic                op_valid,
  input  dfwd_pkg::op_item_t  op_item,
  output logic                op_take,
  input  logic                res_full,
  output logic                res_push,
  output dfwd_pkg::out_item_t res_item
);
  import dfwd_pkg::*;

  localparam int CNTW = $clog2(WINDOW_DEPTH + 1);
  localparam int IW   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

  logic            compare_func_names;
  logic            inited;
  logic            active;
  logic            inited_next;
  logic            active_next;
  logic [CNTW-1:0] entry_count;
  logic [CNTW-1:0] entry_count_next;
  logic [31:0]     outside_cnt;
  logic [31:0]     outside_cnt_next;
  logic [31:0]     inside_cnt;
  logic [31:0]     inside_cnt_next;
  logic [63:0]     entry_addr [WINDOW_DEPTH];
  logic [31:0]     entry_size [WINDOW_DEPTH];
  logic [31:0]     entry_func [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0] lane_hit;
  logic            go;
  logic            ready;
  logic            do_record;
  logic            window_full;

  assign go          = op_valid && !res_full;
  assign op_take     = go;
  assign res_push    = go;
  assign ready       = inited && active;
  assign do_record   = go && ready && (op_item.op == OP_RECORD);
  assign window_full = (entry_count == CNTW'(WINDOW_DEPTH));

  // one compare lane per window entry
  always_comb begin
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      lane_hit[i] = (CNTW'(i) < entry_count)
                    && (!(compare_func_names && op_item.known)
                        || (entry_func[i] == op_item.func))
                    && ranges_overlap(entry_addr[i], entry_size[i],
                                      op_item.addr, op_item.size);
    end
  end

  always_comb begin
    inited_next      = inited;
    active_next      = active;
    entry_count_next = entry_count;
    outside_cnt_next = outside_cnt;
    inside_cnt_next  = inside_cnt;
    case (op_item.op)
      OP_RECORD: begin
        if (ready) begin
          if (!window_full) begin
            entry_count_next = entry_count + 1'b1;
          end
          if (outside_cnt != '1) begin
            outside_cnt_next = outside_cnt + 1'b1;
          end
        end
      end
      OP_CHECK, OP_OUT_WRITE: begin
        if (ready && outside_cnt != '1) begin
          outside_cnt_next = outside_cnt + 1'b1;
        end
      end
      OP_IN_COUNT: begin
        if (ready && inside_cnt != '1) begin
          inside_cnt_next = inside_cnt + 1'b1;
        end
      end
      OP_ACTIVATE:   active_next = 1'b1;
      OP_DEACTIVATE: active_next = 1'b0;
      OP_INIT, OP_DESTROY: begin
        inited_next      = (op_item.op == OP_INIT);
        active_next      = 1'b0;
        entry_count_next = '0;
        outside_cnt_next = '0;
        inside_cnt_next  = '0;
      end
      default: begin
      end
    endcase
  end

  assign res_item.double_fetch  = ready && (op_item.op == OP_CHECK) && (|lane_hit);
  assign res_item.outside_count = outside_cnt_next;
  assign res_item.inside_count  = inside_cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      compare_func_names <= 1'b0;
      inited             <= 1'b0;
      active             <= 1'b0;
      entry_count        <= '0;
      outside_cnt        <= '0;
      inside_cnt         <= '0;
    end else begin
      if (cfg_wr_en) begin
        compare_func_names <= cfg_wr_data;
      end
      if (go) begin
        inited      <= inited_next;
        active      <= active_next;
        entry_count <= entry_count_next;
        outside_cnt <= outside_cnt_next;
        inside_cnt  <= inside_cnt_next;
      end
    end
  end

  // window kept in age order, oldest at index 0
  always_ff @(posedge clk) begin
    if (do_record) begin
      if (!window_full) begin
        entry_addr[entry_count[IW-1:0]] <= op_item.addr;
        entry_size[entry_count[IW-1:0]] <= op_item.size;
        entry_func[entry_count[IW-1:0]] <= op_item.func;
      end else begin
        for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
          entry_addr[i] <= entry_addr[i+1];
          entry_size[i] <= entry_size[i+1];
          entry_func[i] <= entry_func[i+1];
        end
        entry_addr[WINDOW_DEPTH-1] <= op_item.addr;
        entry_size[WINDOW_DEPTH-1] <= op_item.size;
        entry_func[WINDOW_DEPTH-1] <= op_item.func;
      end
    end
  end

endmodule

FILE: design/double_fetch_window_detector_unit.sv
// Double-fetch window detector top level.
// Input channel: an access or lifecycle transaction is taken at a rising edge with push high
// and full low. Result channel: while empty is low the oldest result stands on out_item and
// leaves at an edge with pop high. Every input transaction yields exactly one result.
// Configuration: cfg_wr_en writes cfg_wr_data into the compare-function-names bit at once;
// write it only while no transaction is in flight.
// A taken transaction is decoded into the operation queue; the back end then runs it and pushes
// the result into the result queue, where it becomes visible on out_item.
// Throughput: one transaction per cycle while the result queue is not full; all window entries
// are compared in parallel lanes in the back end.
// When the receiver stops popping, the result queue fills, the back end pauses, the operation
// queue fills and full rises; nothing is dropped.
// Reset clears both queues, the lifecycle flags, the window fill and the counters; the
// configuration bit returns to zero.
module double_fetch_window_detector_unit #(
  parameter int WINDOW_DEPTH = 3
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  dfwd_pkg::in_item_t  in_item,
  output logic                full,
  input  logic                pop,
  output dfwd_pkg::out_item_t out_item,
  output logic                empty,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data
);
  import dfwd_pkg::*;

  op_item_t  dec_item;
  op_item_t  op_item;
  logic      op_empty;
  logic      op_take;
  out_item_t res_item;
  logic      res_push;
  logic      res_full;

  dfwd_front u_front (
    .in_item (in_item),
    .op_item (dec_item)
  );

  dfwd_fifo #(
    .WIDTH ($bits(op_item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_op_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (dec_item),
    .full  (full),
    .pop   (op_take),
    .rdata (op_item),
    .empty (op_empty)
  );

  dfwd_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .op_valid    (!op_empty),
    .op_item     (op_item),
    .op_take     (op_take),
    .res_full    (res_full),
    .res_push    (res_push),
    .res_item    (res_item)
  );

  dfwd_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_item),
    .full  (res_full),
    .pop   (pop),
    .rdata (out_item),
    .empty (empty)
  );

endmodule
